/* rtl/fapt_pkg.sv */
// Package with the constants, codes and helper functions of the frame allocator and page translator.
`default_nettype none

package fapt_pkg;

   localparam int FRAME_COUNT = 16;
   localparam int PAGE_SLOTS  = 256;

   localparam int CMD_W    = 2;
   localparam int FRAME_W  = 4;
   localparam int PAGE_W   = 8;
   localparam int OFFSET_W = 8;
   localparam int VADDR_W  = PAGE_W + OFFSET_W;
   localparam int PADDR_W  = 16;
   localparam int STATUS_W = 2;
   localparam int USED_W   = 5;
   localparam int PPAGES_W = 9;

   localparam int FRAME_AW = $clog2(FRAME_COUNT);
   localparam int PAGE_AW  = $clog2(PAGE_SLOTS);
   localparam int CNT_W    = $clog2(FRAME_COUNT + 1);
   localparam int USED_MAX = (1 << USED_W) - 1;

   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 32;

   localparam logic [CMD_W-1:0] CMD_CLEAR     = 2'd0;
   localparam logic [CMD_W-1:0] CMD_PREOCCUPY = 2'd1;
   localparam logic [CMD_W-1:0] CMD_MAP       = 2'd2;
   localparam logic [CMD_W-1:0] CMD_TRANSLATE = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NO_FREE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd2;
   localparam logic [STATUS_W-1:0] ST_USED    = 2'd3;

   typedef struct packed {
      logic [CMD_W-1:0]    command;
      logic [FRAME_W-1:0]  frame_number;
      logic [PAGE_W-1:0]   page_number;
      logic [VADDR_W-1:0]  virtual_address;
   } req_item_type;

   function automatic logic page_in_range(input logic [PAGE_W-1:0] page,
                                          input logic [PPAGES_W-1:0] pages);
      logic [PPAGES_W-1:0] page_ext;
      logic [PPAGES_W:0]   slots;
      begin
         page_ext = PPAGES_W'(page);
         slots = (PPAGES_W + 1)'(PAGE_SLOTS);
         page_in_range = (page_ext < pages) && ({1'b0, page_ext} < slots);
      end
   endfunction

   function automatic logic [USED_W-1:0] sat_used(input logic [CNT_W-1:0] cnt);
      begin
         if (32'(cnt) > USED_MAX) begin
            sat_used = USED_W'(USED_MAX);
         end else begin
            sat_used = USED_W'(cnt);
         end
      end
   endfunction

endpackage

`default_nettype wire

/* rtl/fapt_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none

module fapt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* rtl/frame_allocator_page_translator_top.sv */
// Top level of the frame allocator and single-level page translator.
//
//   Channel  Direction  Handshake              Payload
//   req      in         req_tvalid/req_tready  tuser: command; tdata: frame, page, address
//   rsp      out        rsp_tvalid/rsp_tready  tuser: status; tdata: address, frame, count
//   csr      in         csr_valid/csr_ready    csr_data: process page count
//
// The page table RAM is read as a word is accepted; in the execute state the block
// decides, writes back and loads the result register. A new word is taken only in the idle
// state. A result held by rsp_tready low keeps the block in its execute state.
// Reset clears the frame marks, the page valid bits and the page count at once.
`default_nettype none

module frame_allocator_page_translator_top (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // frame_number [3:0], page_number [11:4], virtual_address [27:12], zeros above
   input  wire logic [fapt_pkg::REQ_DATA_W-1:0]     req_tdata,
   // command [1:0]
   input  wire logic [fapt_pkg::CMD_W-1:0]          req_tuser,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // physical_address [15:0], granted_frame [19:16], used_frames [24:20], zeros above
   output logic      [fapt_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // status [1:0]
   output logic      [fapt_pkg::STATUS_W-1:0]       rsp_tuser,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [fapt_pkg::PPAGES_W-1:0]       csr_data
);

   import fapt_pkg::*;

   localparam logic S_IDLE = 1'b0;
   localparam logic S_EXEC = 1'b1;

   logic                      state_ff, state_in;
   req_item_type              req_item;
   req_item_type              item_ff;
   logic [PPAGES_W-1:0]       pages_ff;
   logic [FRAME_COUNT-1:0]    frame_used_ff, frame_used_in;
   logic [PAGE_SLOTS-1:0]     page_valid_ff, page_valid_in;
   logic [CNT_W-1:0]          used_cnt_ff, used_cnt_in;
   logic                      valid_rd_ff;
   logic                      rsp_valid_ff;
   logic [PADDR_W-1:0]        rsp_paddr_ff, rsp_paddr_in;
   logic [FRAME_W-1:0]        rsp_grant_ff, rsp_grant_in;
   logic [STATUS_W-1:0]       rsp_status_ff, rsp_status_in;
   logic [USED_W-1:0]         rsp_used_ff;

   logic                      req_accept;
   logic                      exec_done;
   logic [PAGE_W-1:0]         req_vpn;
   logic [FRAME_W-1:0]        ram_rd_frame;
   logic                      ram_wr_en;
   logic                      free_found;
   logic [FRAME_AW-1:0]       first_free;
   logic [FRAME_W-1:0]        fnum;

   assign req_item.command         = req_tuser;
   assign req_item.frame_number    = req_tdata[FRAME_W-1:0];
   assign req_item.page_number     = req_tdata[FRAME_W +: PAGE_W];
   assign req_item.virtual_address = req_tdata[FRAME_W + PAGE_W +: VADDR_W];

   assign req_vpn    = req_item.virtual_address[VADDR_W-1 -: PAGE_W];
   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign exec_done  = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_tready);
   assign csr_ready  = 1'b1;
   assign fnum       = item_ff.frame_number;

   fapt_ram #(
      .WIDTH (FRAME_W),
      .DEPTH (PAGE_SLOTS)
   ) u_page_frame (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (item_ff.page_number[PAGE_AW-1:0]),
      .wr_data (FRAME_W'(first_free)),
      .rd_en   (req_accept),
      .rd_addr (req_vpn[PAGE_AW-1:0]),
      .rd_data (ram_rd_frame)
   );

   always_comb begin
      free_found = 1'b0;
      first_free = '0;
      for (int i = FRAME_COUNT - 1; i >= 0; i--) begin
         if (!frame_used_ff[i]) begin
            free_found = 1'b1;
            first_free = FRAME_AW'(i);
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      frame_used_in = frame_used_ff;
      page_valid_in = page_valid_ff;
      used_cnt_in   = used_cnt_ff;
      rsp_paddr_in  = '0;
      rsp_grant_in  = '0;
      rsp_status_in = ST_OK;
      ram_wr_en     = 1'b0;
      unique case (item_ff.command)
         CMD_CLEAR: begin
            frame_used_in = '0;
            page_valid_in = '0;
            used_cnt_in   = '0;
         end
         CMD_PREOCCUPY: begin
            if (32'(fnum) >= FRAME_COUNT) begin
               rsp_status_in = ST_RANGE;
            end else if (frame_used_ff[fnum[FRAME_AW-1:0]]) begin
               rsp_status_in = ST_USED;
            end else begin
               frame_used_in[fnum[FRAME_AW-1:0]] = 1'b1;
               used_cnt_in = used_cnt_ff + CNT_W'(1);
            end
         end
         CMD_MAP: begin
            if (!page_in_range(item_ff.page_number, pages_ff)) begin
               rsp_status_in = ST_RANGE;
            end else if (!free_found) begin
               rsp_status_in = ST_NO_FREE;
            end else begin
               frame_used_in[first_free] = 1'b1;
               page_valid_in[item_ff.page_number[PAGE_AW-1:0]] = 1'b1;
               used_cnt_in  = used_cnt_ff + CNT_W'(1);
               rsp_grant_in = FRAME_W'(first_free);
               ram_wr_en    = exec_done;
            end
         end
         CMD_TRANSLATE: begin
            if (!page_in_range(item_ff.virtual_address[VADDR_W-1 -: PAGE_W], pages_ff)
                || !valid_rd_ff) begin
               rsp_status_in = ST_RANGE;
            end else begin
               rsp_paddr_in = PADDR_W'({ram_rd_frame,
                                        item_ff.virtual_address[OFFSET_W-1:0]});
            end
         end
         default: begin
            rsp_status_in = ST_OK;
         end
      endcase
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (exec_done) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         pages_ff      <= '0;
         frame_used_ff <= '0;
         page_valid_ff <= '0;
         used_cnt_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            pages_ff <= csr_data;
         end
         if (exec_done) begin
            frame_used_ff <= frame_used_in;
            page_valid_ff <= page_valid_in;
            used_cnt_ff   <= used_cnt_in;
            rsp_valid_ff  <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff  <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         item_ff     <= req_item;
         valid_rd_ff <= page_valid_ff[req_vpn[PAGE_AW-1:0]];
      end
      if (exec_done) begin
         rsp_paddr_ff  <= rsp_paddr_in;
         rsp_grant_ff  <= rsp_grant_in;
         rsp_status_ff <= rsp_status_in;
         rsp_used_ff   <= sat_used(used_cnt_in);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_used_ff, rsp_grant_ff, rsp_paddr_ff});

`ifndef SYNTHESIS
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      32'(used_cnt_ff) <= FRAME_COUNT)
      else $error("used frame count exceeds the number of frames");

   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      32'(used_cnt_ff) == $countones(frame_used_ff))
      else $error("used frame count disagrees with the frame marks");

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == S_EXEC))
      else $error("accepted word did not enter the execute state");

   a_clear_result: assert property (@(posedge clock) disable iff (reset)
      (exec_done && item_ff.command == CMD_CLEAR) |=>
         (rsp_used_ff == '0 && frame_used_ff == '0 && page_valid_ff == '0))
      else $error("clear left frames or pages in use");
`endif

endmodule

`default_nettype wire

/* tb/testbench.sv */
// Self-checking testbench for the frame allocator and page translator.
`timescale 1ns / 100ps

module testbench;
   import fapt_pkg::*;

   typedef enum logic [1:0] {FRAME_FREE, FRAME_PRE, FRAME_MAPPED} frame_mark_type;

   typedef struct {
      logic [PADDR_W-1:0]  phys;
      logic [FRAME_W-1:0]  granted;
      logic [STATUS_W-1:0] status;
      logic [USED_W-1:0]   used;
   } mmu_result_type;

   logic clock;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [CMD_W-1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [STATUS_W-1:0] rsp_tuser;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [PPAGES_W-1:0] csr_data = '0;

   frame_mark_type frame_mark [FRAME_COUNT];
   logic [FRAME_W-1:0] page_table_frame [PAGE_SLOTS];
   logic page_table_valid [PAGE_SLOTS];
   logic [PPAGES_W-1:0] process_pages_model;

   mmu_result_type mmu_expected_q[$];
   int error_count = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   logic hold_rsp = 1'b0;
   int cmd_seen [4];
   int status_seen [4];
   int result_count = 0;

   frame_allocator_page_translator_top u_top (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #400000;
      $display("Timeout with %0d results still pending.", mmu_expected_q.size());
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      for (int i = 0; i < FRAME_COUNT; i++) frame_mark[i] = FRAME_FREE;
      for (int i = 0; i < PAGE_SLOTS; i++) begin
         page_table_frame[i] = '0;
         page_table_valid[i] = 1'b0;
      end
      process_pages_model = '0;
      for (int i = 0; i < 4; i++) begin
         cmd_seen[i] = 0;
         status_seen[i] = 0;
      end
   end

   function automatic logic page_allowed(input logic [PAGE_W-1:0] page);
      return ({1'b0, page} < process_pages_model) && (int'(page) < PAGE_SLOTS);
   endfunction

   function automatic mmu_result_type mmu_predict(input req_item_type w);
      mmu_result_type r;
      logic [PAGE_W-1:0] vpn;
      int free_frame;
      int count;
      r.phys = '0;
      r.granted = '0;
      r.status = ST_OK;
      free_frame = -1;
      case (w.command)
         CMD_CLEAR: begin
            for (int i = 0; i < FRAME_COUNT; i++) frame_mark[i] = FRAME_FREE;
            for (int i = 0; i < PAGE_SLOTS; i++) page_table_valid[i] = 1'b0;
         end
         CMD_PREOCCUPY: begin
            if (int'(w.frame_number) >= FRAME_COUNT) begin
               r.status = ST_RANGE;
            end else if (frame_mark[w.frame_number] != FRAME_FREE) begin
               r.status = ST_USED;
            end else begin
               frame_mark[w.frame_number] = FRAME_PRE;
            end
         end
         CMD_MAP: begin
            if (!page_allowed(w.page_number)) begin
               r.status = ST_RANGE;
            end else begin
               for (int i = FRAME_COUNT - 1; i >= 0; i--) begin
                  if (frame_mark[i] == FRAME_FREE) free_frame = i;
               end
               if (free_frame < 0) begin
                  r.status = ST_NO_FREE;
               end else begin
                  frame_mark[free_frame] = FRAME_MAPPED;
                  page_table_frame[w.page_number] = FRAME_W'(free_frame);
                  page_table_valid[w.page_number] = 1'b1;
                  r.granted = FRAME_W'(free_frame);
               end
            end
         end
         default: begin
            vpn = w.virtual_address[VADDR_W-1:OFFSET_W];
            if (!page_allowed(vpn) || !page_table_valid[vpn]) begin
               r.status = ST_RANGE;
            end else begin
               r.phys = {page_table_frame[vpn], w.virtual_address[OFFSET_W-1:0]};
            end
         end
      endcase
      count = 0;
      for (int i = 0; i < FRAME_COUNT; i++) begin
         if (frame_mark[i] != FRAME_FREE) count++;
      end
      r.used = (count > USED_MAX) ? USED_W'(USED_MAX) : USED_W'(count);
      return r;
   endfunction

   task automatic report_mismatch(input string field, input int want, input int got);
      $display("Mismatch on %s at %0t: expected %0d, got %0d", field, $realtime, want, got);
      error_count++;
   endtask

   always @(posedge clock) begin
      req_item_type w;
      mmu_result_type e;
      if (!reset) begin
         if (csr_valid && csr_ready) process_pages_model = csr_data;
         if (req_tvalid && req_tready) begin
            w.command = req_tuser;
            w.frame_number = req_tdata[3:0];
            w.page_number = req_tdata[11:4];
            w.virtual_address = req_tdata[27:12];
            cmd_seen[w.command]++;
            mmu_expected_q.push_back(mmu_predict(w));
         end
         if (rsp_tvalid && rsp_tready) begin
            result_count++;
            status_seen[rsp_tuser]++;
            if (mmu_expected_q.size() == 0) begin
               report_mismatch("unexpected result word", 0, 1);
            end else begin
               e = mmu_expected_q.pop_front();
               if (rsp_tdata[15:0] !== e.phys)
                  report_mismatch("physical_address", e.phys, rsp_tdata[15:0]);
               if (rsp_tdata[19:16] !== e.granted)
                  report_mismatch("granted_frame", e.granted, rsp_tdata[19:16]);
               if (rsp_tdata[24:20] !== e.used)
                  report_mismatch("used_frames", e.used, rsp_tdata[24:20]);
               if (rsp_tuser !== e.status)
                  report_mismatch("status", e.status, rsp_tuser);
            end
         end
      end
   end

   always @(negedge clock) begin
      rsp_tready = !hold_rsp && ($urandom_range(99) >= recv_stall_pct);
   end

   task automatic send_word(input req_item_type w);
      while ($urandom_range(99) < send_idle_pct) @(negedge clock);
      req_tvalid = 1'b1;
      req_tuser = w.command;
      req_tdata = {4'b0, w.virtual_address, w.page_number, w.frame_number};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   task automatic send_fields(input logic [CMD_W-1:0] cmd, input logic [FRAME_W-1:0] frame,
                              input logic [PAGE_W-1:0] page,
                              input logic [VADDR_W-1:0] vaddr);
      req_item_type w;
      w.command = cmd;
      w.frame_number = frame;
      w.page_number = page;
      w.virtual_address = vaddr;
      send_word(w);
   endtask

   task automatic wait_drained;
      while (mmu_expected_q.size() != 0) @(negedge clock);
   endtask

   task automatic set_pages(input logic [PPAGES_W-1:0] pages);
      wait_drained();
      csr_valid = 1'b1;
      csr_data = pages;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   function automatic logic [PAGE_W-1:0] hot_page;
      int roll;
      int base;
      roll = $urandom_range(99);
      base = int'(process_pages_model) - 8;
      if (base < 0) base = 0;
      if (base > PAGE_SLOTS - 16) base = PAGE_SLOTS - 16;
      if (roll < 45) return PAGE_W'($urandom_range(0, 15));
      if (roll < 85) return PAGE_W'(base + $urandom_range(0, 15));
      return PAGE_W'($urandom);
   endfunction

   function automatic req_item_type random_word;
      req_item_type w;
      int roll;
      w.frame_number = FRAME_W'($urandom);
      w.page_number = PAGE_W'($urandom);
      w.virtual_address = VADDR_W'($urandom);
      roll = $urandom_range(99);
      if (roll < 5) w.command = CMD_CLEAR;
      else if (roll < 20) w.command = CMD_PREOCCUPY;
      else if (roll < 55) w.command = CMD_MAP;
      else w.command = CMD_TRANSLATE;
      if ($urandom_range(99) < 85) begin
         w.page_number = hot_page();
         w.virtual_address[VADDR_W-1:OFFSET_W] = hot_page();
      end
      return w;
   endfunction

   // Edge cases: empty process, boundary pages and frames, reuse, exhaustion and clear.
   task automatic test_directed;
      send_fields(CMD_MAP, 4'd0, 8'd0, 16'h0000);
      send_fields(CMD_TRANSLATE, 4'd0, 8'd0, 16'h0000);
      set_pages(9'd256);
      send_fields(CMD_PREOCCUPY, 4'd15, 8'd0, 16'h0000);
      send_fields(CMD_PREOCCUPY, 4'd15, 8'd0, 16'h0000);
      send_fields(CMD_MAP, 4'd0, 8'd0, 16'h0000);
      send_fields(CMD_MAP, 4'd0, 8'd255, 16'h0000);
      send_fields(CMD_TRANSLATE, 4'd0, 8'd0, 16'h00FF);
      send_fields(CMD_TRANSLATE, 4'd0, 8'd0, 16'hFFFF);
      send_fields(CMD_TRANSLATE, 4'd0, 8'd0, 16'h0100);
      send_fields(CMD_PREOCCUPY, 4'd0, 8'd0, 16'h0000);
      send_fields(CMD_MAP, 4'd0, 8'd0, 16'h0000);
      for (int p = 1; p <= 12; p++) send_fields(CMD_MAP, 4'd0, PAGE_W'(p), 16'h0000);
      send_fields(CMD_MAP, 4'hF, 8'd13, 16'hFFFF);
      send_fields(CMD_CLEAR, 4'hF, 8'hFF, 16'hFFFF);
      send_fields(CMD_TRANSLATE, 4'd0, 8'd0, 16'h0A00);
      wait_drained();
   endtask

   // The receiver holds off while words keep coming, so the block backs up.
   task automatic test_backpressure;
      set_pages(9'd16);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      fork
         begin
            @(posedge clock);
            hold_rsp = 1'b1;
            repeat (150) @(posedge clock);
            hold_rsp = 1'b0;
         end
         for (int i = 0; i < 20; i++) send_word(random_word());
      join
      wait_drained();
   endtask

   task automatic test_random_phase(input logic [PPAGES_W-1:0] pages, input int idle_pct,
                                    input int stall_pct, input int words);
      set_pages(pages);
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      for (int i = 0; i < words; i++) send_word(random_word());
      wait_drained();
   endtask

   initial begin
      repeat (12) @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_backpressure();
      test_random_phase(9'd256, 0, 0, 350);
      test_random_phase(9'd255, 72, 0, 350);
      test_random_phase(9'd1, 0, 72, 150);
      test_random_phase(PPAGES_W'($urandom_range(2, 254)), 33, 33, 350);
      test_random_phase(9'd20, 33, 33, 200);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      wait_drained();
      repeat (8) @(negedge clock);
      if (mmu_expected_q.size() != 0)
         report_mismatch("results left pending", 0, mmu_expected_q.size());
      $display("Sent %0d clear, %0d preoccupy, %0d map and %0d translate words.",
               cmd_seen[CMD_CLEAR], cmd_seen[CMD_PREOCCUPY], cmd_seen[CMD_MAP],
               cmd_seen[CMD_TRANSLATE]);
      $display("Checked %0d results: %0d ok, %0d no free frame, %0d range, %0d used.",
               result_count, status_seen[ST_OK], status_seen[ST_NO_FREE],
               status_seen[ST_RANGE], status_seen[ST_USED]);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

/* frame_allocator_page_translator_top.f */
rtl/fapt_pkg.sv
rtl/fapt_ram.sv
rtl/frame_allocator_page_translator_top.sv
tb/testbench.sv
